@@ rtl/vpm_pkg.sv @@
// ----------------------------------------------------------------------------
// vpm_pkg
// Shared types and constants of the vehicle power mode manager: request and
// result payloads, power modes, request codes and register indexes.
// ----------------------------------------------------------------------------
package vpm_pkg;

    localparam int unsigned TRANS_W    = 9;
    localparam int unsigned INACT_W    = 24;
    localparam int unsigned LEVEL_W    = 10;
    localparam int unsigned DT_W       = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [TRANS_W-1:0] WAKE_TIME_MS     = 9'd200;
    localparam logic [TRANS_W-1:0] SHUTDOWN_TIME_MS = 9'd500;

    typedef enum logic [1:0] {
        MODE_SLEEP    = 2'd0,
        MODE_WAKE     = 2'd1,
        MODE_RUN      = 2'd2,
        MODE_SHUTDOWN = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REQ_IGN_ON  = 3'd0,
        REQ_IGN_OFF = 3'd1,
        REQ_BATTERY = 3'd2,
        REQ_TICK    = 3'd3,
        REQ_RESET   = 3'd4
    } t_req_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLEEP_AFTER = 2'd0,
        CFG_BAT_LOW     = 2'd1,
        CFG_BAT_OK      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [LEVEL_W-1:0] battery_permille;
        logic [DT_W-1:0]    elapsed_ms;
    } t_vpm_req;

    typedef struct packed {
        logic [1:0] power_mode;
        logic       ignition_lamp_on;
        logic       shed_on;
    } t_vpm_rsp;

endpackage

@@ rtl/vehicle_power_mode_manager.sv @@
// ----------------------------------------------------------------------------
// vehicle_power_mode_manager
// Power mode controller: ignition, battery, tick and reset requests drive a
// four-mode state machine with transition and inactivity timers and a
// battery hysteresis that raises load shedding.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ----------------------------
//  request   in         i_in_valid / o_in_stall   i_in_req  (t_vpm_req)
//  result    out        o_out_valid / i_out_stall o_out_rsp (t_vpm_rsp)
//  config    in         i_cfg_we (no stall)       i_cfg_idx, i_cfg_data
//
//  Every request gives exactly one result: it waits in the input register,
//  then passes through the state update into the result register.
//  A new request is accepted every cycle unless the result side stalls; the
//  single pass of small compare and subtract logic in front of the state registers sets this rate.
//  Reset (i_rst_n low, synchronous) empties both registers, returns to sleep
//  with timers stopped, battery judged ok and all thresholds at zero.
//  A stall on the result side holds the result register; the input register
//  then holds too and o_in_stall rises only while it is full.
//
module vehicle_power_mode_manager
    import vpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_vpm_req              i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_vpm_rsp              o_out_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [INACT_W-1:0] r_sleep_after;
    logic [LEVEL_W-1:0] r_bat_low;
    logic [LEVEL_W-1:0] r_bat_ok;

    // Input and result stages
    logic     r_in_valid;
    t_vpm_req r_in;
    logic     r_out_valid;
    t_vpm_rsp r_out;

    // Manager state
    t_mode              r_mode,       n_mode;
    logic [TRANS_W-1:0] r_trans_left, n_trans_left;
    logic               r_trans_run,  n_trans_run;
    logic [INACT_W-1:0] r_inact_left, n_inact_left;
    logic               r_inact_run,  n_inact_run;
    logic               r_bat_good,   n_bat_good;
    logic               r_bat_seen,   n_bat_seen;
    logic               r_shed,       n_shed;

    logic out_load;   // result register free to take a new result
    logic advance;    // request in the input register is processed now

    assign out_load   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep_after <= '0;
            r_bat_low     <= '0;
            r_bat_ok      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLEEP_AFTER: r_sleep_after <= i_cfg_data;
                CFG_BAT_LOW:     r_bat_low     <= i_cfg_data[LEVEL_W-1:0];
                CFG_BAT_OK:      r_bat_ok      <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: load whenever it is empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_req;
        end
    end

    // Next state for the request held in the input register
    always_comb begin
        logic [DT_W-1:0] dt;
        logic            trans_fire;
        logic            inact_fire;

        dt           = r_in.elapsed_ms;
        trans_fire   = 1'b0;
        inact_fire   = 1'b0;
        n_mode       = r_mode;
        n_trans_left = r_trans_left;
        n_trans_run  = r_trans_run;
        n_inact_left = r_inact_left;
        n_inact_run  = r_inact_run;
        n_bat_good   = r_bat_good;
        n_bat_seen   = r_bat_seen;
        n_shed       = r_shed;

        unique case (r_in.req_type)
            REQ_IGN_ON: begin
                if (r_mode == MODE_SLEEP) begin
                    n_mode       = MODE_WAKE;
                    n_trans_left = WAKE_TIME_MS;
                    n_trans_run  = 1'b1;
                end else if (r_mode == MODE_SHUTDOWN) begin
                    // transition timer keeps running; its firing in run is a no-op
                    n_mode       = MODE_RUN;
                    n_inact_left = r_sleep_after;
                    n_inact_run  = 1'b1;
                end
            end
            REQ_IGN_OFF: begin
                if (r_mode == MODE_WAKE || r_mode == MODE_RUN) begin
                    n_mode       = MODE_SHUTDOWN;
                    n_trans_left = SHUTDOWN_TIME_MS;
                    n_trans_run  = 1'b1;
                    n_inact_left = '0;
                    n_inact_run  = 1'b0;
                end
            end
            REQ_BATTERY: begin
                // low test wins when thresholds cross
                if (r_in.battery_permille < r_bat_low) begin
                    n_bat_good = 1'b0;
                end else if (r_in.battery_permille > r_bat_ok) begin
                    n_bat_good = 1'b1;
                end
                if (!r_bat_seen) begin
                    n_bat_seen = 1'b1;
                end else begin
                    n_shed = !n_bat_good;
                end
            end
            REQ_TICK: begin
                // transition timer first
                if (r_trans_run) begin
                    if ({{(DT_W-TRANS_W){1'b0}}, r_trans_left} > dt) begin
                        n_trans_left = r_trans_left - dt[TRANS_W-1:0];
                    end else begin
                        n_trans_left = '0;
                        n_trans_run  = 1'b0;
                        trans_fire   = 1'b1;
                    end
                end
                if (trans_fire) begin
                    if (r_mode == MODE_WAKE) begin
                        n_mode       = MODE_RUN;
                        n_inact_left = r_sleep_after;
                        n_inact_run  = 1'b1;
                    end else if (r_mode == MODE_SHUTDOWN) begin
                        n_mode = MODE_SLEEP;
                    end
                end
                // inactivity timer sees the same elapsed time, even if just started
                if (n_inact_run) begin
                    if (n_inact_left > {{(INACT_W-DT_W){1'b0}}, dt}) begin
                        n_inact_left = n_inact_left - {{(INACT_W-DT_W){1'b0}}, dt};
                    end else begin
                        n_inact_left = '0;
                        n_inact_run  = 1'b0;
                        inact_fire   = 1'b1;
                    end
                end
                if (inact_fire && n_mode == MODE_RUN) begin
                    n_mode       = MODE_SHUTDOWN;
                    n_trans_left = SHUTDOWN_TIME_MS;
                    n_trans_run  = 1'b1;
                end
            end
            REQ_RESET: begin
                // battery_good and thresholds survive
                n_mode       = MODE_SLEEP;
                n_shed       = 1'b0;
                n_trans_left = '0;
                n_trans_run  = 1'b0;
                n_inact_left = '0;
                n_inact_run  = 1'b0;
                n_bat_seen   = 1'b0;
            end
            default: ;
        endcase
    end

    // State registers update only when a request advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SLEEP;
            r_trans_left <= '0;
            r_trans_run  <= 1'b0;
            r_inact_left <= '0;
            r_inact_run  <= 1'b0;
            r_bat_good   <= 1'b1;
            r_bat_seen   <= 1'b0;
            r_shed       <= 1'b0;
        end else if (advance) begin
            r_mode       <= n_mode;
            r_trans_left <= n_trans_left;
            r_trans_run  <= n_trans_run;
            r_inact_left <= n_inact_left;
            r_inact_run  <= n_inact_run;
            r_bat_good   <= n_bat_good;
            r_bat_seen   <= n_bat_seen;
            r_shed       <= n_shed;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.power_mode       <= n_mode;
            r_out.ignition_lamp_on <= (n_mode == MODE_WAKE) || (n_mode == MODE_RUN);
            r_out.shed_on          <= n_shed;
        end
    end

    // Lamp must agree with the reported mode
    a_lamp_matches_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rsp.ignition_lamp_on ==
            ((o_out_rsp.power_mode == MODE_WAKE) || (o_out_rsp.power_mode == MODE_RUN))))
        else $error("lamp does not follow power mode");

    // Inactivity timer only runs in run mode
    a_inact_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inact_run |-> (r_mode == MODE_RUN))
        else $error("inactivity timer running outside run mode");

    // Load shedding needs a primed hysteresis
    a_shed_needs_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shed |-> r_bat_seen)
        else $error("load shed set before first battery reading");

    // Transition timer never exceeds the longest load value
    a_trans_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trans_left <= SHUTDOWN_TIME_MS)
        else $error("transition timer out of range");

endmodule
